// ===== hdl/bpc_pkg.sv =====
// shared types and constants for the button press classifier
// no dependencies

package bpc_pkg;

	localparam int NUM_BUTTONS_DEF = 3;
	localparam int PIN_BITS        = 3;
	localparam int TIME_W          = 32;
	localparam int THRESH_W        = 16;
	localparam int IN_USE_W        = 2;
	localparam int INDEX_W         = 2;
	localparam int CFG_ADDR_W      = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [THRESH_W-1:0] SHORT_PRESS_RST = 16'd50;
	localparam logic [THRESH_W-1:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [IN_USE_W-1:0] IN_USE_RST      = 2'd3;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SHORT_PRESS = 2'd0,
		REG_LONG_PRESS  = 2'd1,
		REG_DIRECT_MODE = 2'd2,
		REG_IN_USE      = 2'd3
	} cfg_reg_t;

	// per button state; code three never arises and acts like up
	typedef enum logic [1:0] {
		MODE_UP   = 2'd0,
		MODE_DOWN = 2'd1,
		MODE_WAIT = 2'd2
	} btn_mode_t;

	typedef struct packed {
		logic [THRESH_W-1:0] short_press_ms;
		logic [THRESH_W-1:0] long_press_ms;
		logic                long_direct_mode;
	} thresh_cfg_t;

	typedef struct packed {
		logic hit;
		logic is_long;
	} lane_evt_t;

	typedef struct packed {
		logic               event_valid;
		logic [INDEX_W-1:0] button_index;
		logic               press_was_long;
	} scan_res_t;

endpackage

// ===== hdl/bpc_lane.sv =====
// one button lane: state, press timestamp and event detection
// depends on bpc_pkg

module bpc_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bpc_pkg::thresh_cfg_t                 cfg,
	input  logic                                 pressed,
	input  logic [bpc_pkg::TIME_W-1:0]           now_ms,
	input  logic                                 upd_en,
	output bpc_pkg::lane_evt_t                   evt
);
	import bpc_pkg::*;

	btn_mode_t           mode_q;
	logic [TIME_W-1:0]   start_q;
	btn_mode_t           mode_nxt;
	logic [TIME_W-1:0]   start_nxt;
	logic [TIME_W-1:0]   delta;
	logic                over_long;
	logic                below_short;

	assign delta       = now_ms - start_q;
	assign over_long   = delta > {{(TIME_W-THRESH_W){1'b0}}, cfg.long_press_ms};
	assign below_short = delta < {{(TIME_W-THRESH_W){1'b0}}, cfg.short_press_ms};

	always_comb begin
		mode_nxt    = mode_q;
		start_nxt   = start_q;
		evt.hit     = 1'b0;
		evt.is_long = 1'b0;
		unique case (mode_q)
			MODE_DOWN: begin
				if (pressed) begin
					if (cfg.long_direct_mode && over_long) begin
						mode_nxt    = MODE_WAIT;
						evt.hit     = 1'b1;
						evt.is_long = 1'b1;
					end
				end else begin
					mode_nxt    = MODE_UP;
					evt.hit     = !below_short;
					evt.is_long = !below_short && over_long;
				end
			end
			MODE_WAIT: begin
				if (!pressed) begin
					mode_nxt = MODE_UP;
				end
			end
			default: begin
				if (pressed) begin
					mode_nxt  = MODE_DOWN;
					start_nxt = now_ms;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UP;
			start_q <= '0;
		end else if (upd_en) begin
			mode_q  <= mode_nxt;
			start_q <= start_nxt;
		end
	end

endmodule

// ===== hdl/bpc_merge.sv =====
// priority merge: picks the first scanned lane with an event and
// gates the updates of later lanes; depends on bpc_pkg

module bpc_merge #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  bpc_pkg::lane_evt_t                 evt [NUM_BUTTONS],
	input  logic [bpc_pkg::IN_USE_W-1:0]       buttons_in_use,
	output logic [NUM_BUTTONS-1:0]             scan,
	output logic [NUM_BUTTONS-1:0]             sel,
	output bpc_pkg::scan_res_t                 res
);
	import bpc_pkg::*;

	logic [NUM_BUTTONS:0] found;

	// a lane is scanned while it is in use and no lower lane has fired
	always_comb begin
		found[0] = 1'b0;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			scan[k]    = (k < int'(buttons_in_use)) && !found[k];
			sel[k]     = scan[k] && evt[k].hit;
			found[k+1] = found[k] || sel[k];
		end
	end

	always_comb begin
		res = '0;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			if (sel[k]) begin
				res.event_valid    = 1'b1;
				res.button_index   = INDEX_W'(k);
				res.press_was_long = evt[k].is_long;
			end
		end
	end

endmodule

// ===== hdl/bpc_outbuf.sv =====
// two-word result buffer: output register plus skid register
// depends on bpc_pkg

module bpc_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bpc_pkg::scan_res_t res_in,
	output logic               can_push,
	output logic               out_valid,
	input  logic               out_ready,
	output bpc_pkg::scan_res_t res_out
);
	import bpc_pkg::*;

	logic      out_valid_q;
	logic      skid_valid_q;
	scan_res_t out_q;
	scan_res_t skid_q;
	logic      out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign res_out   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res_in;
				end
			end else if (push) begin
				out_q <= res_in;
			end
		end else if (push) begin
			skid_q <= res_in;
		end
	end

endmodule

// ===== hdl/button_press_classifier_top.sv =====
// top level of the button press classifier
// depends on bpc_pkg, bpc_lane, bpc_merge, bpc_outbuf

// Classifies short and long presses of up to three active-low buttons. Each
// input word is one scan: the pin levels and a free-running millisecond time
// (wraps at 2^32). Every scan yields exactly one result word; event_valid
// tells whether a button fired, and only the lowest-index button that fires
// is reported, with higher buttons left untouched for that scan. One scan is
// taken per clock cycle while in_ready is high: each button has its own lane
// (state, press time, one 32-bit subtract and two compares) and a priority merge
// folds the lane events into one result in the same cycle, so the next scan sees
// updated state immediately. The result is registered into the output register
// when that register is free as the scan is accepted; while an earlier result
// still waits there, it is held in the skid register and follows as soon as
// that one is taken. A two-word result buffer (output register plus skid)
// keeps in_ready high while one result waits; in_ready drops only when two
// results are pending. Configuration writes take effect on the next cycle
// and should be made while no scan is in flight.

module button_press_classifier_top #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [bpc_pkg::CFG_ADDR_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// scan words in
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bpc_pkg::PIN_BITS-1:0]       pin_levels,
	input  logic [bpc_pkg::TIME_W-1:0]         now_ms,
	// result words out
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               event_valid,
	output logic [bpc_pkg::INDEX_W-1:0]        button_index,
	output logic                               press_was_long
);
	import bpc_pkg::*;

	thresh_cfg_t             cfg_q;
	logic [IN_USE_W-1:0]     in_use_q;
	logic                    accept;
	logic [NUM_BUTTONS-1:0]  pressed;
	logic [NUM_BUTTONS-1:0]  scan;
	logic [NUM_BUTTONS-1:0]  sel;
	lane_evt_t               evt [NUM_BUTTONS];
	scan_res_t               res;
	scan_res_t               res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_ms   <= SHORT_PRESS_RST;
			cfg_q.long_press_ms    <= LONG_PRESS_RST;
			cfg_q.long_direct_mode <= 1'b0;
			in_use_q               <= IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SHORT_PRESS: cfg_q.short_press_ms   <= cfg_wdata[THRESH_W-1:0];
				REG_LONG_PRESS:  cfg_q.long_press_ms    <= cfg_wdata[THRESH_W-1:0];
				REG_DIRECT_MODE: cfg_q.long_direct_mode <= cfg_wdata[0];
				REG_IN_USE:      in_use_q               <= cfg_wdata[IN_USE_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	// one lane per button; buttons beyond the pin field never read as pressed
	for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
		if (k < PIN_BITS) begin : g_pin
			assign pressed[k] = !pin_levels[k];
		end else begin : g_nopin
			assign pressed[k] = 1'b0;
		end

		bpc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.pressed(pressed[k]),
			.now_ms (now_ms),
			.upd_en (accept && scan[k]),
			.evt    (evt[k])
		);
	end

	// lowest firing lane wins
	bpc_merge #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_merge (
		.evt           (evt),
		.buttons_in_use(in_use_q),
		.scan          (scan),
		.sel           (sel),
		.res           (res)
	);

	// result buffer decouples the output handshake
	bpc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.res_in   (res),
		.can_push (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_out  (res_out)
	);

	assign event_valid    = res_out.event_valid;
	assign button_index   = res_out.button_index;
	assign press_was_long = res_out.press_was_long;

	// at most one lane reports per scan
	a_one_winner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel))
		else $error("more than one lane selected in a scan");

	// a word without an event carries zero fields
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> button_index == '0 && !press_was_long)
		else $error("result without event has nonzero fields");

	// after an accepted scan, out_valid is always high in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted scan produced no result");

	// input stalls only when the buffer holds a waiting result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output register");

	// when lane zero fires, no lane above it is scanned
	a_gate_later: assert property (@(posedge clk) disable iff (!arst_n)
		sel[0] |-> (scan >> 1) == '0)
		else $error("lane above a winner was scanned");

endmodule
